[rtl/bba_pkg.sv]
package bba_pkg;

   localparam int NUM_BLOCKS_DEFAULT = 256;
   localparam int WORD_W             = 32;
   localparam int BIT_W              = $clog2(WORD_W);
   localparam int IDX_FIELD_W        = 8;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic ST_DONE = 1'b0;
   localparam logic ST_FULL = 1'b1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_FREE_RD,
      S_FREE_WR,
      S_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic load_req;
      logic addr_clr;
      logic addr_inc;
      logic scan_rd;
      logic free_rd;
      logic clr_wr;
      logic set_wr;
      logic free_wr;
      logic res_grant;
      logic res_full;
      logic res_done;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic chk_valid;
      logic chk_hit;
      logic chk_last;
      logic scan_last;
      logic out_free;
   } dp_status_type;

endpackage

[rtl/bba_datapath.sv]
module bba_datapath
   import bba_pkg::*;
#(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dp_cmd_type             cmd,
   output dp_status_type          dp_status,
   input  logic [IDX_FIELD_W-1:0] req_block_index,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [IDX_FIELD_W-1:0] rsp_alloc_index,
   output logic                   rsp_status
);

   localparam int NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
   localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int LAST_BITS = NUM_BLOCKS - (NUM_WORDS - 1) * WORD_W;
   localparam int GRANT_W   = AW + BIT_W;
   localparam logic [AW-1:0]     LAST_WORD = AW'(NUM_WORDS - 1);
   localparam logic [WORD_W-1:0] LAST_MASK = {WORD_W{1'b1}} >> (WORD_W - LAST_BITS);

   logic [WORD_W-1:0] mem [NUM_WORDS];
   logic [WORD_W-1:0] rd_data_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [WORD_W-1:0] mem_wdata;
   logic [AW-1:0]     mem_raddr;

   logic [IDX_FIELD_W-1:0] idx_ff, idx_in;
   logic [AW-1:0]          scan_addr_ff, scan_addr_in;
   logic                   chk_valid_ff;
   logic [AW-1:0]          chk_addr_ff;

   logic [WORD_W-1:0] free_bits;
   logic              hit;
   logic [BIT_W-1:0]  hit_pos;

   logic [GRANT_W+IDX_FIELD_W-1:0] grant_ext;
   logic [AW+IDX_FIELD_W-1:0]      idx_ext;
   logic [AW-1:0]                  free_word;
   logic [BIT_W-1:0]               free_bit;
   logic                           in_range;

   logic [IDX_FIELD_W-1:0] res_index_ff, res_index_in;
   logic                   res_status_ff, res_status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [IDX_FIELD_W-1:0] rsp_index_ff;
   logic                   rsp_status_ff;

   assign idx_in    = cmd.load_req ? req_block_index : idx_ff;
   assign idx_ext   = {{AW{1'b0}}, idx_ff};
   assign free_word = idx_ext[AW+BIT_W-1:BIT_W];
   assign free_bit  = idx_ff[BIT_W-1:0];
   assign in_range  = ({24'd0, idx_ff} < 32'(NUM_BLOCKS));

   assign free_bits = ~rd_data_ff & ((chk_addr_ff == LAST_WORD) ? LAST_MASK : {WORD_W{1'b1}});
   assign hit       = |free_bits;

   always_comb begin
      hit_pos = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            hit_pos = BIT_W'(i);
         end
      end
   end

   assign grant_ext = (GRANT_W + IDX_FIELD_W)'({chk_addr_ff, hit_pos});

   always_comb begin
      scan_addr_in = scan_addr_ff;
      priority if (cmd.addr_clr) begin
         scan_addr_in = '0;
      end else if (cmd.addr_inc && (scan_addr_ff != LAST_WORD)) begin
         scan_addr_in = scan_addr_ff + AW'(1);
      end
   end

   assign mem_raddr = (cmd.free_rd && in_range) ? free_word : scan_addr_ff;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = scan_addr_ff;
      mem_wdata = '0;
      priority if (cmd.clr_wr) begin
         mem_we    = 1'b1;
         mem_waddr = scan_addr_ff;
         mem_wdata = '0;
      end else if (cmd.set_wr) begin
         mem_we    = 1'b1;
         mem_waddr = chk_addr_ff;
         mem_wdata = rd_data_ff | (WORD_W'(1) << hit_pos);
      end else if (cmd.free_wr) begin
         mem_we    = in_range;
         mem_waddr = free_word;
         mem_wdata = rd_data_ff & ~(WORD_W'(1) << free_bit);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   always_comb begin
      res_index_in  = res_index_ff;
      res_status_in = res_status_ff;
      priority if (cmd.res_grant) begin
         res_index_in  = grant_ext[IDX_FIELD_W-1:0];
         res_status_in = ST_DONE;
      end else if (cmd.res_full) begin
         res_index_in  = '0;
         res_status_in = ST_FULL;
      end else if (cmd.res_done) begin
         res_index_in  = '0;
         res_status_in = ST_DONE;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_addr_ff <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         scan_addr_ff <= scan_addr_in;
         chk_valid_ff <= cmd.scan_rd;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      chk_addr_ff   <= scan_addr_ff;
      res_index_ff  <= res_index_in;
      res_status_ff <= res_status_in;
      if (cmd.out_load) begin
         rsp_index_ff  <= res_index_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign dp_status.chk_valid = chk_valid_ff;
   assign dp_status.chk_hit   = hit;
   assign dp_status.chk_last  = (chk_addr_ff == LAST_WORD);
   assign dp_status.scan_last = (scan_addr_ff == LAST_WORD);
   assign dp_status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_alloc_index = rsp_index_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

[rtl/bba_ctrl.sv]
module bba_ctrl
   import bba_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_type,
   input  dp_status_type dp_status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (dp_status.scan_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = (req_type == REQ_FREE) ? S_FREE_RD : S_SCAN;
            end
         end
         S_SCAN: begin
            if (dp_status.chk_valid && (dp_status.chk_hit || dp_status.chk_last)) begin
               state_in = S_OUT;
            end
         end
         S_FREE_RD: state_in = S_FREE_WR;
         S_FREE_WR: state_in = S_OUT;
         S_OUT: begin
            if (dp_status.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr   = 1'b1;
            cmd.addr_inc = 1'b1;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               cmd.addr_clr = 1'b1;
            end
         end
         S_SCAN: begin
            cmd.scan_rd  = 1'b1;
            cmd.addr_inc = 1'b1;
            if (dp_status.chk_valid) begin
               if (dp_status.chk_hit) begin
                  cmd.set_wr    = 1'b1;
                  cmd.res_grant = 1'b1;
               end else if (dp_status.chk_last) begin
                  cmd.res_full = 1'b1;
               end
            end
         end
         S_FREE_RD: cmd.free_rd = 1'b1;
         S_FREE_WR: begin
            cmd.free_wr  = 1'b1;
            cmd.res_done = 1'b1;
         end
         S_OUT: cmd.out_load = dp_status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

[rtl/bitmap_block_allocator_top.sv]
// First-fit block allocator over a usage map of NUM_BLOCKS blocks, one bit per block.
// A request transaction on the req_ channel either allocates the lowest-numbered free
// block (req_type 0) or frees req_block_index (req_type 1). Each request produces one
// response transaction on the rsp_ channel: the granted index and a status that is set
// when no block was free. Frees of free blocks or of indexes past the map are harmless.
// The map is held in a memory of 32-bit words and an allocate reads it one word per
// cycle, picking the first free bit of a word with a priority encoder.
// An allocate scans the words in order from word 0 until a word has a free bit or the
// last word is checked; a free reads the word holding the index, clears its bit and
// writes the word back. The result then waits for the output register to be free.
// Requests are handled one at a time; the memory's single read port sets the scan pace.
// After reset the block writes zeros to every map word, one word per cycle, and req_ready
// stays low during that pass.
// The response sits in an output register, so the next request is accepted while an
// earlier response waits. If the receiver stalls, a finished result waits in the block
// and new requests stop being accepted until the output register drains.
module bitmap_block_allocator_top
   import bba_pkg::*;
#(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_type,
   input  logic [IDX_FIELD_W-1:0] req_block_index,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [IDX_FIELD_W-1:0] rsp_alloc_index,
   output logic                   rsp_status
);

   dp_cmd_type    cmd;
   dp_status_type dp_status;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   bba_datapath #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .dp_status       (dp_status),
      .req_block_index (req_block_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_alloc_index (rsp_alloc_index),
      .rsp_status      (rsp_status)
   );

endmodule

[rtl/bba_checker.sv]
module bba_checker
   import bba_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [IDX_FIELD_W-1:0] rsp_alloc_index,
   input logic                   rsp_status
);

   // A stalled response must hold its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_alloc_index) && $stable(rsp_status))
      else $error("response changed while stalled");

   // The map is cleared after reset before any request is taken.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("block active right after reset");

   // A failed allocate carries index zero.
   a_full_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> (rsp_alloc_index == '0))
      else $error("full response with nonzero index");

   // Only one request is in work at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in work");

endmodule

bind bitmap_block_allocator_top bba_checker u_bba_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_alloc_index (rsp_alloc_index),
   .rsp_status      (rsp_status)
);

[sim/tb_top.sv]
module tb_top
   import bba_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAP_SIZE    = NUM_BLOCKS_DEFAULT;
   localparam int LONG_HOLD   = 80;
   localparam int QUIET_LIMIT = 3000;
   localparam int SETTLE      = 16;

   typedef struct packed {
      logic [IDX_FIELD_W-1:0] index;
      logic                   status;
   } grant_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_type;
   logic [IDX_FIELD_W-1:0] req_block_index;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [IDX_FIELD_W-1:0] rsp_alloc_index;
   logic                   rsp_status;

   bit [MAP_SIZE-1:0] block_used;
   grant_type         pending_grants[$];
   int                mismatches = 0;
   bit                calm = 1'b0;
   int                holds_asked = 0;
   int                holds_served = 0;
   int                hold_left = 0;
   int                rsp_wait = 0;
   int                quiet_cycles = 0;

   bitmap_block_allocator_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_block_index(req_block_index),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_alloc_index(rsp_alloc_index),
      .rsp_status     (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   // Applies one accepted request to the local copy of the map and returns its response.
   function automatic grant_type apply_request(input logic kind,
                                               input logic [IDX_FIELD_W-1:0] idx);
      grant_type result;
      result.index  = '0;
      result.status = ST_DONE;
      if (kind == REQ_ALLOC) begin
         result.status = ST_FULL;
         for (int k = 0; k < MAP_SIZE; k++) begin
            if (!block_used[k]) begin
               block_used[k] = 1'b1;
               result.index  = k[IDX_FIELD_W-1:0];
               result.status = ST_DONE;
               break;
            end
         end
      end else if (int'(idx) < MAP_SIZE) begin
         block_used[idx] = 1'b0;
      end
      return result;
   endfunction

   task automatic send_request(input logic kind, input logic [IDX_FIELD_W-1:0] idx);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 7);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_block_index <= idx;
      do @(posedge clock); while (!req_ready);
      pending_grants.push_back(apply_request(kind, idx));
   endtask

   task automatic send_random_alloc();
      send_request(REQ_ALLOC, IDX_FIELD_W'($urandom_range(0, 255)));
   endtask

   task automatic send_random_free();
      send_request(REQ_FREE, IDX_FIELD_W'($urandom_range(0, 255)));
   endtask

   task automatic test_directed();
      send_request(REQ_ALLOC, 8'h00);
      send_request(REQ_ALLOC, 8'hFF);
      send_request(REQ_ALLOC, 8'hA5);
      send_request(REQ_FREE,  8'h01);
      send_request(REQ_ALLOC, 8'h5A);
      send_request(REQ_FREE,  8'hFF);
      send_request(REQ_FREE,  8'h80);
      send_request(REQ_FREE,  8'h01);
      send_request(REQ_FREE,  8'h01);
      send_request(REQ_FREE,  8'h00);
      send_request(REQ_ALLOC, 8'h7F);
      send_request(REQ_ALLOC, 8'h01);
      send_request(REQ_ALLOC, 8'h80);
      send_request(REQ_FREE,  8'h02);
      send_request(REQ_FREE,  8'h00);
      send_request(REQ_ALLOC, 8'hFF);
      send_request(REQ_ALLOC, 8'h00);
   endtask

   // Mostly allocates, so the scan walks every word and the map ends up full.
   task automatic test_fill_map();
      while (block_used != '1) begin
         if ($urandom_range(0, 9) == 0) send_random_free();
         else send_random_alloc();
      end
      repeat (6) send_random_alloc();
      send_request(REQ_FREE, 8'hFF);
      send_request(REQ_ALLOC, 8'h00);
      send_request(REQ_ALLOC, 8'h00);
      send_request(REQ_FREE, 8'hE0);
      send_request(REQ_ALLOC, 8'h3C);
   endtask

   // The receiver stalls for a long stretch while requests keep coming.
   task automatic test_back_pressure();
      calm = 1'b1;
      holds_asked++;
      for (int i = 0; i < 12; i++) begin
         if (i % 3 == 2) send_random_free();
         else send_random_alloc();
      end
      calm = 1'b0;
   endtask

   task automatic test_random_mix();
      for (int i = 0; i < 130; i++) begin
         calm = (i < 30);
         if ($urandom_range(0, 1) == 0) send_random_alloc();
         else send_random_free();
      end
      calm = 1'b0;
   endtask

   task automatic finish_run();
      req_valid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (pending_grants.size() != 0) report_mismatch("responses still outstanding at end");
      if (mismatches == 0) begin
         $display("bitmap_block_allocator_top: match");
      end else begin
         $display("bitmap_block_allocator_top: mismatch");
      end
      $finish;
   endtask

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_type        <= REQ_ALLOC;
      req_block_index <= '0;
      block_used      = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_fill_map();
      test_back_pressure();
      test_random_mix();
      finish_run();
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait  <= 0;
         hold_left <= 0;
      end else if (holds_served != holds_asked) begin
         holds_served <= holds_asked;
         hold_left    <= LONG_HOLD;
         rsp_ready    <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= (hold_left == 1);
      end else if (rsp_valid && rsp_ready) begin
         int gap;
         gap = calm ? 0 : $urandom_range(0, 7);
         rsp_wait  <= gap;
         rsp_ready <= (gap == 0);
      end else if (rsp_wait != 0) begin
         rsp_wait  <= rsp_wait - 1;
         rsp_ready <= (rsp_wait == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         grant_type want;
         if (pending_grants.size() == 0) begin
            report_mismatch("response transaction with no request pending");
         end else begin
            want = pending_grants.pop_front();
            if (rsp_alloc_index !== want.index)
               report_mismatch($sformatf("alloc_index %0d, expected %0d",
                                         rsp_alloc_index, want.index));
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0b, expected %0b", rsp_status, want.status));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("ERROR at %0t: no transaction for %0d cycles", $realtime, QUIET_LIMIT);
            $display("bitmap_block_allocator_top: mismatch");
            $finish;
         end
      end
   end

endmodule
